FILE: hdl/tpem_pkg.sv
// Shared constants for the three-phase energy meter: default parameters,
// stream payload widths and phase codes. No dependencies.
package tpem_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned DeltaBitsDef  = 24;

  // fixed field widths of the stream payloads
  localparam int unsigned FieldW     = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned PhaseW     = 2;
  localparam int unsigned PhPowW     = 33;
  localparam int unsigned TotPowW    = 34;
  localparam int unsigned PeakW      = 33;
  localparam int unsigned EnergyW    = 64;
  localparam int unsigned InTdataW   = 104;
  localparam int unsigned InTuserW   = 2;
  localparam int unsigned OutTdataW  = 296;
  localparam int unsigned OutTuserW  = 1;

  localparam logic [PhaseW-1:0] PhaseA = 2'd0;
  localparam logic [PhaseW-1:0] PhaseB = 2'd1;
  localparam logic [PhaseW-1:0] PhaseC = 2'd2;

endpackage

FILE: hdl/three_phase_energy_meter.sv
// Three-phase power, demand and energy meter built round one shared multiplier.
// Depends on tpem_pkg.
//
// channel   dir  tdata (low bit up)                                  tuser
// s_axis    in   volt_re, volt_im, curr_re, curr_im, sample_time,    phase_index
//                clear_demand, zero pad to 104 bits
// m_axis    out  phase_real_power, phase_reactive_power,             totals_valid
//                total_real_power, total_reactive_power, peak_demand,
//                real_energy, reactive_energy, zero pad to 296 bits
//
// A transaction runs from the accepting cycle through four multiplier passes for
// the complex power to a result state, which holds the result while m_axis is
// stalled; the input is not ready again until it is done. A phase A transaction
// that books energy also runs two partial products on the single multiplier, a
// saturation and a saturating add for each of real and reactive energy. Reset
// clears control state, accumulators and output valid, not the payload registers.
module three_phase_energy_meter #(
  parameter int unsigned SAMPLE_BITS = tpem_pkg::SampleBitsDef,
  parameter int unsigned DELTA_BITS  = tpem_pkg::DeltaBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [tpem_pkg::InTdataW-1:0]  s_axis_tdata_i,   // see table above
  input  logic [tpem_pkg::InTuserW-1:0]  s_axis_tuser_i,   // phase_index
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [tpem_pkg::OutTdataW-1:0] m_axis_tdata_o,   // see table above
  output logic [tpem_pkg::OutTuserW-1:0] m_axis_tuser_o    // totals_valid
);

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned DB   = DELTA_BITS;
  localparam int unsigned FW   = (SB > tpem_pkg::FieldW) ? SB : tpem_pkg::FieldW;
  localparam int unsigned PW   = 2 * SB + 1;           // phase power
  localparam int unsigned SW   = 2 * SB + 2;           // running sums, totals, peak
  localparam int unsigned SW1  = SW + 1;
  localparam int unsigned C    = SB + 1;               // magnitude chunk
  localparam int unsigned BW   = (DB > SB) ? DB : SB;
  localparam int unsigned AW   = SB + 2;               // multiplier operand a
  localparam int unsigned BW1  = BW + 1;               // multiplier operand b
  localparam int unsigned MW   = AW + BW1;
  localparam int unsigned EPW  = SW + DB;              // energy product magnitude
  localparam int unsigned EW   = (EPW > 64) ? EPW : 64;
  localparam int unsigned LW   = C + DB;               // one partial product
  localparam int unsigned TW   = tpem_pkg::TimeW;
  localparam int unsigned NW   = tpem_pkg::EnergyW;

  localparam logic signed [SW1-1:0] SumMax = SW1'((64'sd1 <<< (2 * SB + 1)) - 64'sd1);
  localparam logic signed [SW1-1:0] SumMin = -SumMax - SW1'(1);
  localparam logic [DB-1:0]         DtMax  = '1;
  localparam logic [EW-1:0]         EMagMax = EW'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam logic signed [NW-1:0]  EMax   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [NW-1:0]  EMin   = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ELO, S_EHI, S_ESAT, S_EACC, S_FIN
  } state_e;

  state_e                           state_q;
  logic [1:0]                       step_q;
  logic                             chan_q;
  logic [tpem_pkg::PhaseW-1:0]      phase_q;
  logic                             clr_q;
  logic                             en_q;
  logic [DB-1:0]                    dt_q;
  logic signed [SB-1:0]             vr_q, vi_q, ir_q, ii_q;
  logic signed [PW-1:0]             pr_q, pq_q;
  logic [LW-1:0]                    part_q;
  logic [EPW-1:0]                   emag_q;
  logic signed [NW-1:0]             eprod_q;
  logic [TW-1:0]                    last_time_q;
  logic signed [SW-1:0]             prev_re_q, prev_im_q;
  logic signed [SW-1:0]             run_re_q, run_im_q;
  logic signed [SW-1:0]             peak_q;
  logic signed [NW-1:0]             ereal_q, ereact_q;
  logic                             out_valid_q;
  logic [tpem_pkg::OutTdataW-1:0]   out_data_q;
  logic [tpem_pkg::OutTuserW-1:0]   out_user_q;

  // input decode
  logic [FW-1:0]   f_vr, f_vi, f_ir, f_ii;
  logic [TW-1:0]   in_time, diff;
  logic            accept;

  assign accept  = s_axis_tvalid_i && (state_q == S_IDLE);
  assign f_vr    = FW'(s_axis_tdata_i[15:0]);
  assign f_vi    = FW'(s_axis_tdata_i[31:16]);
  assign f_ir    = FW'(s_axis_tdata_i[47:32]);
  assign f_ii    = FW'(s_axis_tdata_i[63:48]);
  assign in_time = s_axis_tdata_i[95:64];
  assign diff    = in_time - last_time_q;

  // shared multiplier
  logic signed [AW-1:0]  mul_a;
  logic signed [BW1-1:0] mul_b;
  logic signed [MW-1:0]  prod;
  logic signed [SW-1:0]  psel;
  logic                  pneg;
  logic [SW-1:0]         pmag;

  assign psel = chan_q ? prev_im_q : prev_re_q;
  assign pneg = psel[SW-1];
  assign pmag = pneg ? SW'(-psel) : SW'(psel);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL: begin
        unique case (step_q)
          2'd0: begin mul_a = AW'(vr_q); mul_b = BW1'(ir_q); end
          2'd1: begin mul_a = AW'(vi_q); mul_b = BW1'(ii_q); end
          2'd2: begin mul_a = AW'(vi_q); mul_b = BW1'(ir_q); end
          default: begin mul_a = AW'(vr_q); mul_b = BW1'(ii_q); end
        endcase
      end
      S_ELO: begin
        mul_a = AW'({1'b0, pmag[C-1:0]});
        mul_b = BW1'({1'b0, dt_q});
      end
      S_EHI: begin
        mul_a = AW'({1'b0, pmag[SW-1:C]});
        mul_b = BW1'({1'b0, dt_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // energy saturation and accumulation
  logic [EW-1:0]        emag_e;
  logic signed [NW-1:0] eacc_sel;
  logic signed [NW:0]   esum;
  logic signed [NW-1:0] esum_sat;

  assign emag_e   = EW'(emag_q);
  assign eacc_sel = chan_q ? ereact_q : ereal_q;
  assign esum     = {eacc_sel[NW-1], eacc_sel} + {eprod_q[NW-1], eprod_q};
  assign esum_sat = (esum[NW] != esum[NW-1]) ? (esum[NW] ? EMin : EMax) : esum[NW-1:0];

  // result cycle
  logic                 ph_a, ph_bc, ph_c;
  logic signed [SW1-1:0] nsum_re, nsum_im;
  logic signed [SW-1:0]  csum_re, csum_im;
  logic signed [SW-1:0]  peak_base, peak_new;
  logic                  out_free;

  assign ph_a  = (phase_q == tpem_pkg::PhaseA);
  assign ph_c  = (phase_q == tpem_pkg::PhaseC);
  assign ph_bc = (phase_q == tpem_pkg::PhaseB) || ph_c;

  assign nsum_re = ph_a ? SW1'(pr_q) : SW1'(run_re_q) + SW1'(pr_q);
  assign nsum_im = ph_a ? SW1'(pq_q) : SW1'(run_im_q) + SW1'(pq_q);

  always_comb begin
    if (nsum_re > SumMax)      csum_re = SW'(SumMax);
    else if (nsum_re < SumMin) csum_re = SW'(SumMin);
    else                       csum_re = SW'(nsum_re);
    if (nsum_im > SumMax)      csum_im = SW'(SumMax);
    else if (nsum_im < SumMin) csum_im = SW'(SumMin);
    else                       csum_im = SW'(nsum_im);
  end

  assign peak_base = clr_q ? '0 : peak_q;
  assign peak_new  = (ph_c && (csum_re > peak_base)) ? csum_re : peak_base;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      chan_q      <= 1'b0;
      last_time_q <= '0;
      prev_re_q   <= '0;
      prev_im_q   <= '0;
      run_re_q    <= '0;
      run_im_q    <= '0;
      peak_q      <= '0;
      ereal_q     <= '0;
      ereact_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            step_q  <= '0;
            chan_q  <= 1'b0;
            state_q <= S_MUL;
            if ((s_axis_tuser_i == tpem_pkg::PhaseA) && (in_time > last_time_q)) begin
              last_time_q <= in_time;
            end
          end
        end
        S_MUL: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd3) begin
            state_q <= (ph_a && en_q) ? S_ELO : S_FIN;
          end
        end
        S_ELO:  state_q <= S_EHI;
        S_EHI:  state_q <= S_ESAT;
        S_ESAT: state_q <= S_EACC;
        S_EACC: begin
          if (chan_q) begin
            ereact_q <= esum_sat;
            state_q  <= S_FIN;
          end else begin
            ereal_q <= esum_sat;
            chan_q  <= 1'b1;
            state_q <= S_ELO;
          end
        end
        S_FIN: begin
          if (out_free) begin
            peak_q      <= peak_new;
            if (ph_a || ph_bc) begin
              run_re_q <= csum_re;
              run_im_q <= csum_im;
            end
            if (ph_c) begin
              prev_re_q <= csum_re;
              prev_im_q <= csum_im;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      phase_q <= s_axis_tuser_i;
      clr_q   <= s_axis_tdata_i[96];
      vr_q    <= f_vr[SB-1:0];
      vi_q    <= f_vi[SB-1:0];
      ir_q    <= f_ir[SB-1:0];
      ii_q    <= f_ii[SB-1:0];
      if (in_time > last_time_q) begin
        dt_q <= (diff > TW'(DtMax)) ? DtMax : diff[DB-1:0];
        en_q <= (last_time_q != '0);
      end else begin
        dt_q <= '0;
        en_q <= 1'b0;
      end
    end
    if (state_q == S_MUL) begin
      unique case (step_q)
        2'd0: pr_q <= PW'(prod);
        2'd1: pr_q <= pr_q + PW'(prod);
        2'd2: pq_q <= PW'(prod);
        default: pq_q <= pq_q - PW'(prod);
      endcase
    end
    if (state_q == S_ELO) begin
      part_q <= prod[LW-1:0];
    end
    if (state_q == S_EHI) begin
      emag_q <= EPW'(part_q) + (EPW'(prod[LW-1:0]) << C);
    end
    if (state_q == S_ESAT) begin
      if (emag_e > EMagMax) begin
        eprod_q <= pneg ? EMin : EMax;
      end else begin
        eprod_q <= pneg ? -signed'(emag_e[NW-1:0]) : signed'(emag_e[NW-1:0]);
      end
    end
    if ((state_q == S_FIN) && out_free) begin
      out_user_q <= ph_c;
      out_data_q <= {
        1'b0,
        ereact_q,
        ereal_q,
        tpem_pkg::PeakW'(peak_new),
        ph_c ? tpem_pkg::TotPowW'(csum_im) : tpem_pkg::TotPowW'(0),
        ph_c ? tpem_pkg::TotPowW'(csum_re) : tpem_pkg::TotPowW'(0),
        tpem_pkg::PhPowW'(pq_q),
        tpem_pkg::PhPowW'(pr_q)
      };
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
